/* hw/rtl/ofmc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ofmc_pkg
// Shared types, codes and the turn-time function of the follow mode controller
// ----------------------------------------------------------------------------
package ofmc_pkg;

  localparam logic [7:0]  FRONT_DEGREES = 8'd90;
  localparam logic [31:0] SETTLE_MS     = 32'd500;
  localparam logic [10:0] TURN_MIN_MS   = 11'd200;
  localparam logic [10:0] TURN_MAX_MS   = 11'd1200;
  localparam logic [12:0] TURN_SCALE    = 13'd34;
  localparam logic [13:0] RECIP_SEVEN   = 14'd9363;

  localparam int unsigned CFG_ADDR_W = 4;

  localparam logic [1:0] REG_SEARCH_THR = 2'd0;
  localparam logic [1:0] REG_LOST_DIST  = 2'd1;
  localparam logic [1:0] REG_TOO_CLOSE  = 2'd2;
  localparam logic [1:0] REG_DRIVE_SPD  = 2'd3;

  typedef enum logic [1:0] {
    MODE_SEARCH  = 2'd0,
    MODE_TURN    = 2'd1,
    MODE_FORWARD = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    MC_NONE  = 3'd0,
    MC_STOP  = 3'd1,
    MC_FWD   = 3'd2,
    MC_RIGHT = 3'd3,
    MC_LEFT  = 3'd4
  } motor_cmd_t;

  typedef enum logic [1:0] {
    SC_NONE        = 2'd0,
    SC_SEARCH      = 2'd1,
    SC_CENTER      = 2'd2,
    SC_STOP_CENTER = 2'd3
  } servo_cmd_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [9:0]  distance_cm;
    logic        servo_idle;
    logic        object_found;
    logic [7:0]  object_angle;
  } in_t;

  typedef struct packed {
    logic [2:0] motor_cmd;
    logic [7:0] motor_speed;
    logic [1:0] servo_cmd;
    logic [1:0] mode;
  } out_t;

  typedef struct packed {
    logic [9:0] search_threshold_cm;
    logic [9:0] lost_distance_cm;
    logic [9:0] too_close_cm;
    logic [7:0] drive_speed;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] phase_start_ms;
    logic [10:0] turn_time_ms;
    logic        recentered;
  } state_t;

  // floor(d * 34 / 7) via reciprocal multiply, exact for d * 34 below 13107
  function automatic logic [10:0] turn_ms(input logic [7:0] angle);
    logic [7:0]  d;
    logic [12:0] x;
    logic [26:0] prod;
    logic [10:0] t;
    d    = (angle >= FRONT_DEGREES) ? (angle - FRONT_DEGREES) : (FRONT_DEGREES - angle);
    x    = {5'd0, d} * TURN_SCALE;
    prod = {14'd0, x} * {13'd0, RECIP_SEVEN};
    t    = prod[26:16];
    if (t < TURN_MIN_MS) t = TURN_MIN_MS;
    if (t > TURN_MAX_MS) t = TURN_MAX_MS;
    return t;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/ofmc_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ofmc_step
// Next-state and result logic for one control tick
// ----------------------------------------------------------------------------
module ofmc_step (
  input  ofmc_pkg::in_t    item,
  input  ofmc_pkg::cfg_t   cfg,
  input  ofmc_pkg::state_t st,
  output ofmc_pkg::state_t st_nxt,
  output ofmc_pkg::out_t   res
);
  import ofmc_pkg::*;

  logic [31:0] elapsed;
  motor_cmd_t  motor;
  servo_cmd_t  servo;
  logic        dist_zero;

  assign elapsed   = item.now_ms - st.phase_start_ms;
  assign dist_zero = (item.distance_cm == 10'd0);

  always_comb begin
    st_nxt = st;
    motor  = MC_NONE;
    servo  = SC_NONE;
    case (st.mode)
      MODE_TURN: begin
        if (elapsed < {21'd0, st.turn_time_ms}) begin
          motor = MC_NONE;
        end else if (!st.recentered) begin
          motor                 = MC_STOP;
          servo                 = SC_CENTER;
          st_nxt.recentered     = 1'b1;
          st_nxt.phase_start_ms = item.now_ms;
        end else if (elapsed >= SETTLE_MS) begin
          if (!dist_zero && item.distance_cm <= cfg.search_threshold_cm) begin
            st_nxt.mode = MODE_FORWARD;
          end else begin
            servo       = SC_STOP_CENTER;
            st_nxt.mode = MODE_SEARCH;
          end
        end
      end
      MODE_FORWARD: begin
        if (item.servo_idle) servo = SC_CENTER;
        if (dist_zero || item.distance_cm > cfg.lost_distance_cm) begin
          motor       = MC_STOP;
          servo       = SC_STOP_CENTER;
          st_nxt.mode = MODE_SEARCH;
        end else if (item.distance_cm <= cfg.too_close_cm) begin
          motor = MC_STOP;
        end else if (item.distance_cm <= cfg.search_threshold_cm) begin
          motor = MC_FWD;
        end
      end
      default: begin
        st_nxt.mode = MODE_SEARCH;
        if (item.servo_idle) servo = SC_SEARCH;
        if (item.object_found && item.servo_idle) begin
          if (item.object_angle == FRONT_DEGREES) begin
            st_nxt.mode = MODE_FORWARD;
          end else begin
            st_nxt.turn_time_ms   = turn_ms(item.object_angle);
            if (item.object_angle < FRONT_DEGREES) begin
              motor = MC_RIGHT;
            end else begin
              motor = MC_LEFT;
            end
            st_nxt.phase_start_ms = item.now_ms;
            st_nxt.recentered     = 1'b0;
            st_nxt.mode           = MODE_TURN;
          end
        end
      end
    endcase
  end

  always_comb begin
    res.motor_cmd   = motor;
    res.motor_speed = (motor == MC_FWD || motor == MC_RIGHT || motor == MC_LEFT) ?
                      cfg.drive_speed : 8'd0;
    res.servo_cmd   = servo;
    res.mode        = st_nxt.mode;
  end

endmodule
`default_nettype wire

/* hw/rtl/object_follow_mode_controller.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// object_follow_mode_controller
// Search, turn and forward mode control for an object-following car
// ----------------------------------------------------------------------------
// Each input transaction is one control tick: time, distance, servo idle flag
// and any found object angle. Each tick gives exactly one result transaction
// with the motor command, motor speed, servo command and the new mode.
// An accepted tick is held in an input register, then the mode logic runs
// and the result is written to the output register; one tick per cycle is
// sustained while the receiver does not stall. The only feedback path is
// the mode state register, updated in the same cycle the result register is
// loaded. When the receiver stalls, the result holds and the input register
// still takes one more tick; in_stall rises only once both registers are
// full. Reset (synchronous, rst_n low) empties both registers, returns to
// search mode and restores the register defaults. Registers are written
// through the APB-style port at byte offsets 0, 4, 8 and 12. The user must
// write them only while the block is idle; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
module object_follow_mode_controller (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  ofmc_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output ofmc_pkg::out_t                   out_data,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [ofmc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire  [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import ofmc_pkg::*;

  logic     s1_valid_r, s1_valid_nxt;
  in_t      s1_data_r;
  logic     out_valid_r, out_valid_nxt;
  out_t     out_data_r;
  state_t   st_r, st_nxt;
  cfg_t     cfg_r;
  out_t     res;
  logic     adv;
  logic     in_acc;
  logic     cfg_wr;
  logic [1:0] reg_idx;

  assign adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_acc = in_valid && !in_stall;
  assign in_stall  = s1_valid_r && !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_wr    = psel && penable && pwrite && pready;

  ofmc_step u_step (
    .item   (s1_data_r),
    .cfg    (cfg_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{mode: MODE_SEARCH, phase_start_ms: 32'd0,
                       turn_time_ms: 11'd0, recentered: 1'b0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_data_r <= in_data;
    if (adv) out_data_r <= res;
  end

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{search_threshold_cm: 10'd50, lost_distance_cm: 10'd60,
                 too_close_cm: 10'd10, drive_speed: 8'd150};
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SEARCH_THR: cfg_r.search_threshold_cm <= pwdata[9:0];
        REG_LOST_DIST:  cfg_r.lost_distance_cm    <= pwdata[9:0];
        REG_TOO_CLOSE:  cfg_r.too_close_cm        <= pwdata[9:0];
        REG_DRIVE_SPD:  cfg_r.drive_speed         <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SEARCH_THR: prdata = {22'd0, cfg_r.search_threshold_cm};
      REG_LOST_DIST:  prdata = {22'd0, cfg_r.lost_distance_cm};
      REG_TOO_CLOSE:  prdata = {22'd0, cfg_r.too_close_cm};
      REG_DRIVE_SPD:  prdata = {24'd0, cfg_r.drive_speed};
      default:        prdata = 32'd0;
    endcase
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  a_speed_only_when_moving: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.motor_speed != 8'd0) |->
      (out_data_r.motor_cmd == MC_FWD || out_data_r.motor_cmd == MC_RIGHT ||
       out_data_r.motor_cmd == MC_LEFT))
    else $error("speed given without a drive command");

  a_turn_enters_turn_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.motor_cmd == MC_RIGHT || out_data_r.motor_cmd == MC_LEFT))
      |-> (out_data_r.mode == MODE_TURN))
    else $error("turn command without turn mode");

  a_turn_time_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.mode == MODE_TURN) |->
      (st_r.turn_time_ms >= TURN_MIN_MS && st_r.turn_time_ms <= TURN_MAX_MS))
    else $error("turn time out of range");

endmodule
`default_nettype wire

/* test/tb_object_follow_mode_controller.sv */
// ----------------------------------------------------------------------------
// tb_object_follow_mode_controller
// Self-checking bench for the search, turn and forward mode controller
// ----------------------------------------------------------------------------
// Control ticks go in on the valid/stall input channel, and commands are
// collected on the output channel. Both sides idle in random bursts. A
// scoreboard keeps its own copy of the mode state and the registers. It works
// out the command for every accepted tick and compares each returned command
// field by field, in order. A directed set of ticks walks every mode change,
// the turn-time clamp, angles past 180 and timer wrap. Random phases follow
// under several register settings, extremes included. Each phase is mostly
// coherent time sequences with distances near the thresholds, plus some
// random noise. Registers are written and read back over the APB port only
// while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_object_follow_mode_controller;
  import ofmc_pkg::*;

  class follow_scoreboard;
    logic [9:0]  search_thr;
    logic [9:0]  lost_dist;
    logic [9:0]  too_close;
    logic [7:0]  speed;
    mode_t       mode_now;
    logic [31:0] phase_start;
    logic [10:0] turn_time;
    bit          recentered;
    out_t        due_commands[$];
    int          errors;

    function void clear();
      search_thr  = 10'd50;
      lost_dist   = 10'd60;
      too_close   = 10'd10;
      speed       = 8'd150;
      mode_now    = MODE_SEARCH;
      phase_start = '0;
      turn_time   = '0;
      recentered  = 1'b0;
      errors      = 0;
      due_commands.delete();
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_SEARCH_THR: search_thr = value[9:0];
        REG_LOST_DIST:  lost_dist  = value[9:0];
        REG_TOO_CLOSE:  too_close  = value[9:0];
        REG_DRIVE_SPD:  speed      = value[7:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_SEARCH_THR: return {22'd0, search_thr};
        REG_LOST_DIST:  return {22'd0, lost_dist};
        REG_TOO_CLOSE:  return {22'd0, too_close};
        default:        return {24'd0, speed};
      endcase
    endfunction

    // |angle - front| * 34 / 7 ms, clamped
    function logic [10:0] turn_duration(logic [7:0] angle);
      int unsigned offset;
      int unsigned ms;
      offset = (angle >= FRONT_DEGREES) ? angle - FRONT_DEGREES : FRONT_DEGREES - angle;
      ms = offset * 34 / 7;
      if (ms < TURN_MIN_MS) ms = TURN_MIN_MS;
      if (ms > TURN_MAX_MS) ms = TURN_MAX_MS;
      return ms[10:0];
    endfunction

    function void note_tick(in_t tick);
      logic [31:0] elapsed;
      motor_cmd_t  motor;
      servo_cmd_t  servo;
      out_t        cmd;
      motor = MC_NONE;
      servo = SC_NONE;
      case (mode_now)
        MODE_TURN: begin
          elapsed = tick.now_ms - phase_start;
          if (elapsed >= {21'd0, turn_time}) begin
            if (!recentered) begin
              motor       = MC_STOP;
              servo       = SC_CENTER;
              recentered  = 1'b1;
              phase_start = tick.now_ms;
            end else if (elapsed >= SETTLE_MS) begin
              if (tick.distance_cm != 0 && tick.distance_cm <= search_thr) begin
                mode_now = MODE_FORWARD;
              end else begin
                servo    = SC_STOP_CENTER;
                mode_now = MODE_SEARCH;
              end
            end
          end
        end
        MODE_FORWARD: begin
          if (tick.servo_idle) servo = SC_CENTER;
          if (tick.distance_cm == 0 || tick.distance_cm > lost_dist) begin
            motor    = MC_STOP;
            servo    = SC_STOP_CENTER;
            mode_now = MODE_SEARCH;
          end else if (tick.distance_cm <= too_close) begin
            motor = MC_STOP;
          end else if (tick.distance_cm <= search_thr) begin
            motor = MC_FWD;
          end
        end
        default: begin
          mode_now = MODE_SEARCH;
          if (tick.servo_idle) begin
            servo = SC_SEARCH;
            if (tick.object_found) begin
              if (tick.object_angle == FRONT_DEGREES) begin
                mode_now = MODE_FORWARD;
              end else begin
                turn_time   = turn_duration(tick.object_angle);
                if (tick.object_angle < FRONT_DEGREES) begin
                  motor = MC_RIGHT;
                end else begin
                  motor = MC_LEFT;
                end
                phase_start = tick.now_ms;
                recentered  = 1'b0;
                mode_now    = MODE_TURN;
              end
            end
          end
        end
      endcase
      cmd.motor_cmd   = motor;
      cmd.motor_speed = (motor == MC_FWD || motor == MC_RIGHT || motor == MC_LEFT) ? speed : 8'd0;
      cmd.servo_cmd   = servo;
      cmd.mode        = mode_now;
      due_commands.push_back(cmd);
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_command(out_t got);
      out_t want;
      if (due_commands.size() == 0) begin
        $display("%0t: command with none expected, actual %p", $time, got);
        errors++;
        return;
      end
      want = due_commands.pop_front();
      compare("motor_cmd", 8'(want.motor_cmd), 8'(got.motor_cmd));
      compare("motor_speed", want.motor_speed, got.motor_speed);
      compare("servo_cmd", 8'(want.servo_cmd), 8'(got.servo_cmd));
      compare("mode", 8'(want.mode), 8'(got.mode));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  follow_scoreboard sb;
  int               busy_pct;
  logic [31:0]      sim_ms;

  object_follow_mode_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_tick(in_data);
      if (out_valid && !out_stall) sb.check_command(out_data);
    end
  end

  // receiver stalls in bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (busy_pct != 0 && $urandom_range(1, 100) <= busy_pct / 3) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send(input in_t tick);
    if (busy_pct != 0 && $urandom_range(1, 100) <= busy_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= tick;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic tick(input logic [31:0] now, input logic [9:0] distance, input logic idle,
                      input logic found, input logic [7:0] angle);
    in_t t;
    t.now_ms       = now;
    t.distance_cm  = distance;
    t.servo_idle   = idle;
    t.object_found = found;
    t.object_angle = angle;
    send(t);
  endtask

  task automatic drain();
    @(posedge clk);
    while (sb.due_commands.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  task automatic write_and_verify(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    apb_xfer(1'b1, idx, value, rd);
    sb.set_reg(idx, value);
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== sb.reg_value(idx)) begin
      $display("%0t: register %0d expected %0d actual %0d", $time, idx, sb.reg_value(idx), rd);
      sb.errors++;
    end
  endtask

  task automatic program_regs(input logic [9:0] thr, input logic [9:0] lost,
                              input logic [9:0] close, input logic [7:0] spd);
    write_and_verify(REG_SEARCH_THR, {22'd0, thr});
    write_and_verify(REG_LOST_DIST, {22'd0, lost});
    write_and_verify(REG_TOO_CLOSE, {22'd0, close});
    write_and_verify(REG_DRIVE_SPD, {24'd0, spd});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [9:0] pick_distance();
    logic [9:0] base;
    case ($urandom_range(0, 5))
      0: return 10'($urandom_range(0, 1023));
      1: base = sb.search_thr;
      2: base = sb.lost_dist;
      3: base = sb.too_close;
      4: return $urandom_range(0, 1) ? 10'd0 : 10'd1023;
      default: return 10'($urandom_range(1, 70));
    endcase
    return base + 10'($urandom_range(0, 2)) - 10'd1;
  endfunction

  function automatic in_t random_tick();
    in_t t;
    if ($urandom_range(0, 99) < 5) begin
      t.now_ms       = $urandom;
      t.distance_cm  = 10'($urandom);
      t.servo_idle   = 1'($urandom);
      t.object_found = 1'($urandom);
      t.object_angle = 8'($urandom);
      return t;
    end
    case ($urandom_range(0, 3))
      0:       sim_ms += $urandom_range(0, 40);
      1:       sim_ms += $urandom_range(0, 300);
      2:       sim_ms += $urandom_range(300, 900);
      default: sim_ms += $urandom_range(0, 1300);
    endcase
    if ($urandom_range(0, 199) == 0) sim_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
    t.now_ms       = sim_ms;
    t.distance_cm  = pick_distance();
    t.servo_idle   = $urandom_range(0, 9) < 7;
    t.object_found = $urandom_range(0, 3) == 0;
    t.object_angle = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 180));
    if ($urandom_range(0, 9) == 0) t.object_angle = FRONT_DEGREES;
    return t;
  endfunction

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    busy_pct = 0;
    sim_ms   = '0;
    sb = new();
    sb.clear();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    busy_pct = 25;
    // busy servo ignores the object, then search and straight-ahead catch
    tick(32'd1000, 10'd20, 1'b0, 1'b1, 8'd30);
    tick(32'd1010, 10'd20, 1'b1, 1'b0, 8'd30);
    tick(32'd1020, 10'd20, 1'b1, 1'b1, FRONT_DEGREES);
    tick(32'd1030, 10'd5, 1'b1, 1'b0, 8'd0);
    tick(32'd1040, 10'd30, 1'b0, 1'b0, 8'd0);
    tick(32'd1050, 10'd55, 1'b0, 1'b0, 8'd0);
    tick(32'd1060, 10'd0, 1'b0, 1'b0, 8'd0);
    // hard right, turn edge, settle edge
    tick(32'd2000, 10'd20, 1'b1, 1'b1, 8'd0);
    tick(32'd2436, 10'd20, 1'b0, 1'b0, 8'd0);
    tick(32'd2437, 10'd20, 1'b0, 1'b0, 8'd0);
    tick(32'd2936, 10'd20, 1'b1, 1'b0, 8'd0);
    tick(32'd2937, 10'd20, 1'b0, 1'b0, 8'd0);
    tick(32'd2940, 10'd1023, 1'b1, 1'b0, 8'd0);
    // angle past 180, then no reading after settling
    tick(32'd3000, 10'd20, 1'b1, 1'b1, 8'd255);
    tick(32'd4000, 10'd20, 1'b0, 1'b0, 8'd0);
    tick(32'd4500, 10'd0, 1'b0, 1'b0, 8'd0);
    // minimum turn time, object out of range after settling
    tick(32'd5000, 10'd60, 1'b1, 1'b1, 8'd89);
    tick(32'd5200, 10'd60, 1'b0, 1'b0, 8'd0);
    tick(32'd5700, 10'd51, 1'b0, 1'b0, 8'd0);
    // turn across the timer wrap
    tick(32'hFFFF_FF00, 10'd50, 1'b1, 1'b1, 8'd180);
    tick(32'h0000_00A0, 10'd50, 1'b0, 1'b0, 8'd0);
    tick(32'h0000_00B5, 10'd50, 1'b0, 1'b0, 8'd0);
    tick(32'h0000_02A9, 10'd1, 1'b0, 1'b0, 8'd0);
    tick(32'h0000_02AA, 10'd10, 1'b1, 1'b1, 8'd0);
    in_valid <= 1'b0;
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: program_regs(10'd1, 10'd1, 10'd0, 8'd0);
        1: program_regs(10'd1023, 10'd1023, 10'd1023, 8'd255);
        2: program_regs(10'd50, 10'd60, 10'd10, 8'd150);
        default: program_regs(10'($urandom_range(20, 200)), 10'($urandom_range(30, 300)),
                              10'($urandom_range(0, 40)), 8'($urandom));
      endcase
      case (ph)
        0:       busy_pct = 25;
        1:       busy_pct = 40;
        2:       busy_pct = 10;
        3:       busy_pct = 30;
        default: busy_pct = 0;
      endcase
      sim_ms = $urandom;
      repeat (350) send(random_tick());
      in_valid <= 1'b0;
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.due_commands.size() == 0) begin
      $display("tb_object_follow_mode_controller: PASS");
    end else begin
      $display("tb_object_follow_mode_controller: FAIL");
    end
    $finish;
  end

  initial begin
    #(12 * 400_000);
    $display("tb_object_follow_mode_controller: FAIL");
    $finish;
  end

endmodule
